// ----- hdl/gdfs_pkg.sv -----
package gdfs_pkg;

    // Fixed field widths of the stream items
    localparam int VTX_W         = 5;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;

    // Default graph size, and a maximum size that no module here checks
    localparam int VERTICES_DEF  = 16;
    localparam int VERTICES_MAX  = 64;

    // Item kinds carried on the slave tuser
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_SEARCH   = 1'b1;

endpackage

// ----- hdl/gdfs_adj_mem.sv -----
module gdfs_adj_mem
    import gdfs_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [$clog2(VERTICES)-1:0] i_waddr,
    input  logic [VERTICES-1:0]         i_wdata,
    input  logic [$clog2(VERTICES)-1:0] i_raddr,
    output logic [VERTICES-1:0]         o_rdata
);

    logic [VERTICES-1:0] r_mem [VERTICES];
    logic [VERTICES-1:0] r_row_valid;
    logic [VERTICES-1:0] r_rd_data;
    logic                r_rd_valid;

    // Row storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    // Row valid bits: a row never written reads as no edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_row_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- hdl/gdfs_stack.sv -----
module gdfs_stack
    import gdfs_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(VERTICES)-1:0] i_waddr,
    input  logic [$clog2(VERTICES)-1:0] i_wdata,
    input  logic [$clog2(VERTICES)-1:0] i_raddr,
    output logic [$clog2(VERTICES)-1:0] o_rdata
);

    localparam int IW = $clog2(VERTICES);

    logic [IW-1:0] r_mem [VERTICES];
    logic [IW-1:0] r_rd_data;

    // Pending vertex store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_data;

endmodule

// ----- hdl/gdfs_pick.sv -----
module gdfs_pick
    import gdfs_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic [VERTICES-1:0]         i_cand,
    output logic                        o_any,
    output logic [$clog2(VERTICES)-1:0] o_idx
);

    localparam int IW = $clog2(VERTICES);

    // Find the highest set candidate bit; later hits override earlier ones
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < VERTICES; i++) begin
            if (i_cand[i]) begin
                o_idx = IW'(i);
            end
        end
        o_any = |i_cand;
    end

endmodule

// ----- hdl/graph_depth_first_search.sv -----
// Add edge: reads and rewrites the row of vertex_a, then that of vertex_b, then returns to idle.
// Search: per popped vertex, S_POP (stack read) and S_LOAD (row read), then S_SCAN pushes
// each unvisited neighbour and finishes the row scan (S_SCAN is skipped on a key match),
// then S_EMIT holds the result until m_axis_tready; S_IDLE is entered after the last.
// One item at a time: s_axis_tready stays low until the whole run has finished.
// Reset clears control state and the adjacency row valid bits at once.
module graph_depth_first_search
    import gdfs_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [4:0] vertex_a, [9:5] vertex_b, [14:10] search_key, [15] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [4:0] visited_vertex, [7:5] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int IW    = $clog2(VERTICES);
    localparam int CW    = $clog2(VERTICES + 1);
    localparam int CMP_W = (CW > VTX_W) ? CW : VTX_W;
    localparam logic [VERTICES-1:0] ONE_HOT0 = VERTICES'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_RD_B,
        S_ADD_WR_B,
        S_POP,
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx_a, n_idx_a;
    logic [IW-1:0]       r_idx_b, n_idx_b;
    logic [IW-1:0]       r_cur, n_cur;
    logic [CW-1:0]       r_count, n_count;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [VTX_W-1:0]    r_out_vtx, n_out_vtx;
    logic                r_out_found, n_out_found;
    logic                r_out_last, n_out_last;

    logic [VTX_W-1:0]    in_va, in_vb, in_key;
    logic                va_ok, vb_ok;
    logic [IW-1:0]       va_idx, vb_idx;
    logic                in_acc;

    logic                adj_we;
    logic [IW-1:0]       adj_waddr, adj_raddr;
    logic [VERTICES-1:0] adj_wdata, adj_row;
    logic                stk_we;
    logic [IW-1:0]       stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic                pick_any;
    logic [IW-1:0]       pick_idx;
    logic [VTX_W-1:0]    load_vtx;
    logic                load_hit;
    logic [VTX_W-1:0]    r_key, n_key;

    // Unpack the input transaction
    assign in_va  = s_axis_tdata[VTX_W-1:0];
    assign in_vb  = s_axis_tdata[2*VTX_W-1:VTX_W];
    assign in_key = s_axis_tdata[3*VTX_W-1:2*VTX_W];
    assign va_ok  = (in_va != '0) && (CMP_W'(in_va) <= CMP_W'(VERTICES));
    assign vb_ok  = (in_vb != '0) && (CMP_W'(in_vb) <= CMP_W'(VERTICES));
    assign va_idx = IW'(CMP_W'(in_va) - CMP_W'(1));
    assign vb_idx = IW'(CMP_W'(in_vb) - CMP_W'(1));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Vertex number of the entry just read from the stack, and the key match
    assign load_vtx = VTX_W'(CMP_W'(stk_rdata) + CMP_W'(1));
    assign load_hit = (CMP_W'(r_key) == CMP_W'(stk_rdata) + CMP_W'(1));

    gdfs_adj_mem #(.VERTICES(VERTICES)) u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_row)
    );

    gdfs_stack #(.VERTICES(VERTICES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    gdfs_pick #(.VERTICES(VERTICES)) u_pick (
        .i_cand (adj_row & ~r_visited),
        .o_any  (pick_any),
        .o_idx  (pick_idx)
    );

    // Sequencer: next state and memory port control
    always_comb begin
        n_state     = r_state;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_cur       = r_cur;
        n_count     = r_count;
        n_visited   = r_visited;
        n_key       = r_key;
        n_out_vtx   = r_out_vtx;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        adj_we      = 1'b0;
        adj_waddr   = r_idx_a;
        adj_wdata   = adj_row;
        adj_raddr   = r_idx_a;
        stk_we      = 1'b0;
        stk_waddr   = IW'(r_count);
        stk_wdata   = pick_idx;
        stk_raddr   = IW'(r_count - CW'(1));

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx_a = va_idx;
                    n_idx_b = vb_idx;
                    n_key   = in_key;
                    if (s_axis_tuser == OP_ADD_EDGE) begin
                        if (va_ok && vb_ok) begin
                            n_state = S_ADD_RD_A;
                        end
                    end else if (va_ok) begin
                        // Seed the stack with the start vertex
                        n_visited = ONE_HOT0 << va_idx;
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = va_idx;
                        n_count   = CW'(1);
                        n_state   = S_POP;
                    end
                end
            end
            S_ADD_RD_A: begin
                adj_raddr = r_idx_a;
                n_state   = S_ADD_WR_A;
            end
            S_ADD_WR_A: begin
                adj_we    = 1'b1;
                adj_waddr = r_idx_a;
                adj_wdata = adj_row | (ONE_HOT0 << r_idx_b);
                n_state   = S_ADD_RD_B;
            end
            S_ADD_RD_B: begin
                adj_raddr = r_idx_b;
                n_state   = S_ADD_WR_B;
            end
            S_ADD_WR_B: begin
                adj_we    = 1'b1;
                adj_waddr = r_idx_b;
                adj_wdata = adj_row | (ONE_HOT0 << r_idx_a);
                n_state   = S_IDLE;
            end
            S_POP: begin
                stk_raddr = IW'(r_count - CW'(1));
                n_count   = r_count - CW'(1);
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                // Fetch the popped vertex's row; stop at once on a key match
                n_cur     = stk_rdata;
                adj_raddr = stk_rdata;
                if (load_hit) begin
                    n_out_vtx   = load_vtx;
                    n_out_found = 1'b1;
                    n_out_last  = 1'b1;
                    n_count     = '0;
                    n_state     = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                adj_raddr = r_cur;
                if (pick_any) begin
                    // Push the highest unvisited neighbour and mark it
                    n_visited = r_visited | (ONE_HOT0 << pick_idx);
                    if (r_count < CW'(VERTICES)) begin
                        stk_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    n_out_vtx   = VTX_W'(CMP_W'(r_cur) + CMP_W'(1));
                    n_out_found = 1'b0;
                    n_out_last  = (r_count == '0);
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_axis_tready) begin
                    n_state = r_out_last ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_visited <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_visited <= n_visited;
        end
        r_idx_a     <= n_idx_a;
        r_idx_b     <= n_idx_b;
        r_cur       <= n_cur;
        r_key       <= n_key;
        r_out_vtx   <= n_out_vtx;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tdata  = M_TDATA_W'(r_out_vtx);
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- test/graph_depth_first_search_tb.sv -----
`timescale 1ns / 100ps

module graph_depth_first_search_tb;
    import gdfs_pkg::*;

    localparam int N_VTX       = VERTICES_DEF;
    localparam int RANDOM_OPS  = 350;
    localparam int QUIET_TAIL  = 50;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 40;

    typedef struct {
        logic       op;
        logic [4:0] vtx_a;
        logic [4:0] vtx_b;
        logic [4:0] key;
        bit         drain;
    } t_graph_op;

    typedef struct {
        logic [4:0] vertex;
        logic       found;
        logic       last;
    } t_visit;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [4:0] vertex_a, [9:5] vertex_b, [14:10] search_key, [15] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [0] opcode
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [4:0] visited_vertex, [7:5] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] found
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // Shadow copy of the graph and the queues around it
    logic [N_VTX-1:0] adj_rows [N_VTX];
    t_graph_op        op_queue[$];
    t_visit           visit_queue[$];
    t_graph_op        on_bus;
    int               gap_left   = 0;
    int               stall_left = 0;
    int               idle_count = 0;
    int               mismatches = 0;
    logic             quiet_tail = 1'b0;

    graph_depth_first_search #(
        .VERTICES(N_VTX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Generate the clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit is_vertex(logic [4:0] v);
        return v >= 1 && v <= N_VTX;
    endfunction

    // Update the shadow graph, or walk it and queue the visits a search gives
    task automatic apply_graph_op(t_graph_op g);
        logic [N_VTX-1:0] seen;
        logic [4:0]       pend[$];
        logic [4:0]       cur;
        t_visit           vis;
        int               emitted;
        begin
            if (g.op == OP_ADD_EDGE) begin
                if (is_vertex(g.vtx_a) && is_vertex(g.vtx_b)) begin
                    adj_rows[g.vtx_a - 1][g.vtx_b - 1] = 1'b1;
                    adj_rows[g.vtx_b - 1][g.vtx_a - 1] = 1'b1;
                end
            end else if (is_vertex(g.vtx_a)) begin
                seen    = '0;
                emitted = 0;
                pend.push_back(g.vtx_a);
                seen[g.vtx_a - 1] = 1'b1;
                while (pend.size() > 0 && emitted < N_VTX) begin
                    cur       = pend.pop_back();
                    vis.found = (cur == g.key);
                    // Push unvisited neighbours, highest index first
                    if (!vis.found) begin
                        for (int i = N_VTX; i >= 1; i--) begin
                            if (adj_rows[cur - 1][i - 1] && !seen[i - 1]) begin
                                pend.push_back(5'(i));
                                seen[i - 1] = 1'b1;
                            end
                        end
                    end
                    vis.vertex = cur;
                    vis.last   = vis.found || pend.size() == 0;
                    visit_queue.push_back(vis);
                    emitted++;
                    if (vis.found) begin
                        pend.delete();
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, int want, int got);
        begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    function automatic t_graph_op make_op(logic op, int a, int b, int k, bit drain = 1'b0);
        t_graph_op g;
        begin
            g.op    = op;
            g.vtx_a = 5'(a);
            g.vtx_b = 5'(b);
            g.key   = 5'(k);
            g.drain = drain;
            return g;
        end
    endfunction

    // Sender: present queued items, with random gaps between transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_graph_op(on_bus);
                if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 13);
                end
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_queue.size() > 0 &&
                             !(op_queue[0].drain && visit_queue.size() != 0)) begin
                    on_bus = op_queue.pop_front();
                    s_axis_tdata  <= {1'b0, on_bus.key, on_bus.vtx_b, on_bus.vtx_a};
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            quiet_tail <= (op_queue.size() < QUIET_TAIL);
        end
    end

    // Receiver: check each visit against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        t_visit want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (visit_queue.size() == 0) begin
                    report_mismatch("unexpected visit, vertex", -1, int'(m_axis_tdata));
                end else begin
                    want = visit_queue.pop_front();
                    if (m_axis_tdata !== {3'b000, want.vertex}) begin
                        report_mismatch("visited vertex", int'(want.vertex),
                                        int'(m_axis_tdata));
                    end
                    if (m_axis_tuser !== want.found) begin
                        report_mismatch("found flag", int'(want.found), int'(m_axis_tuser));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch("last flag", int'(want.last), int'(m_axis_tlast));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_count <= 0;
            end else if (idle_count >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
    end

    initial begin
        bit noise;
        int k;
        for (int r = 0; r < N_VTX; r++) begin
            adj_rows[r] = '0;
        end

        // Empty graph, then vertices outside the graph
        op_queue.push_back(make_op(OP_SEARCH,   1,  0,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 0,  5,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 17, 3,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 31, 31, 31));
        op_queue.push_back(make_op(OP_SEARCH,   0,  0,  1));
        op_queue.push_back(make_op(OP_SEARCH,   31, 31, 0));
        op_queue.push_back(make_op(OP_SEARCH,   17, 0,  17));
        // Self loop and two small components
        op_queue.push_back(make_op(OP_ADD_EDGE, 1,  1,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 1,  2,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 2,  16, 0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 16, 3,  0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 1,  16, 0));
        op_queue.push_back(make_op(OP_ADD_EDGE, 5,  6,  0));
        // Whole walk, hit mid-walk, hit at the start, keys that match nothing
        op_queue.push_back(make_op(OP_SEARCH,   1,  0,  0));
        op_queue.push_back(make_op(OP_SEARCH,   1,  0,  16, 1'b1));
        op_queue.push_back(make_op(OP_SEARCH,   16, 0,  16));
        op_queue.push_back(make_op(OP_SEARCH,   1,  0,  17));
        op_queue.push_back(make_op(OP_SEARCH,   3,  31, 31));
        op_queue.push_back(make_op(OP_SEARCH,   5,  0,  6));
        op_queue.push_back(make_op(OP_SEARCH,   9,  0,  9));
        op_queue.push_back(make_op(OP_SEARCH,   16, 0,  1));

        // Grow the graph mostly early, keep searching it throughout
        for (int n = 0; n < RANDOM_OPS; n++) begin
            noise = ($urandom_range(0, 7) == 0);
            if (noise) begin
                op_queue.push_back(make_op(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                                           $urandom_range(0, 31), $urandom_range(0, 31),
                                           $urandom_range(0, 49) == 0));
            end else if ($urandom_range(0, 99) < (n < 100 ? 40 : 8)) begin
                op_queue.push_back(make_op(OP_ADD_EDGE, $urandom_range(1, N_VTX),
                                           $urandom_range(1, N_VTX), $urandom_range(0, 31)));
            end else begin
                k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, N_VTX);
                op_queue.push_back(make_op(OP_SEARCH, $urandom_range(1, N_VTX),
                                           $urandom_range(0, 31), k,
                                           $urandom_range(0, 24) == 0));
            end
        end

        // Hold reset, then release
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain stimulus and expectations, then let the block settle
        while (op_queue.size() > 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (visit_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (visit_queue.size() != 0) begin
            report_mismatch("visits outstanding at end", 0, visit_queue.size());
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gdfs_pkg.sv
hdl/gdfs_adj_mem.sv
hdl/gdfs_stack.sv
hdl/gdfs_pick.sv
hdl/graph_depth_first_search.sv
test/graph_depth_first_search_tb.sv
